/* rtl/afprf_pkg.sv */
// Package for the aligned free page range finder.
// Holds geometry constants, status codes and the transaction structs.
// No dependencies.
package afprf_pkg;

  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_BITS  = 32;
  localparam int PN_BITS    = ADDR_BITS - PAGE_SHIFT;
  localparam int WORD_BITS  = 64;
  localparam int WSEL_BITS  = 6;
  localparam int WIDX_BITS  = (PN_BITS > WSEL_BITS) ? PN_BITS - WSEL_BITS : 1;
  localparam int MAP_WORDS  = 1 << WIDX_BITS;
  localparam int WIDE_BITS  = 34;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_RANGE = 3'd1;
  localparam logic [2:0] ST_BAD_ALIGN = 3'd2;
  localparam logic [2:0] ST_SIZE_OVER = 3'd3;
  localparam logic [2:0] ST_NO_SPACE  = 3'd4;

  typedef struct packed {
    logic        action;
    logic [19:0] page_number;
    logic        mapped_value;
    logic [32:0] range_length;
    logic [31:0] search_begin;
    logic [32:0] search_end;
    logic [32:0] align_step;
    logic [32:0] align_offset;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_address;
  } out_item_t;

endpackage

/* rtl/afprf_divider.sv */
// Restoring divider for 34-bit unsigned values, one quotient bit per cycle.
// Depends on afprf_pkg.
module afprf_divider
  import afprf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [WIDE_BITS-1:0] num,
  input  logic [WIDE_BITS-1:0] den,
  output logic                 done,
  output logic [WIDE_BITS-1:0] quo,
  output logic [WIDE_BITS-1:0] rem
);

  logic [WIDE_BITS-1:0] q_r, q_nxt, r_r, r_nxt, d_r;
  logic [5:0]           cnt_r, cnt_nxt;
  logic                 run_r, run_nxt, done_r, done_nxt;
  logic [WIDE_BITS:0]   sh;

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    sh       = {r_r, q_r[WIDE_BITS-1]};
    if (go) begin
      q_nxt   = num;
      r_nxt   = '0;
      cnt_nxt = 6'(WIDE_BITS);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (sh >= {1'b0, d_r}) begin
        r_nxt = WIDE_BITS'(sh - {1'b0, d_r});
        q_nxt = {q_r[WIDE_BITS-2:0], 1'b1};
      end else begin
        r_nxt = sh[WIDE_BITS-1:0];
        q_nxt = {q_r[WIDE_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (go) d_r <= den;
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r;

endmodule

/* rtl/afprf_map_ram.sv */
// Page map memory: one 64-bit word per row, one port, registered read.
// Depends on afprf_pkg.
module afprf_map_ram
  import afprf_pkg::*;
(
  input  logic                 clk,
  input  logic                 we,
  input  logic [WIDX_BITS-1:0] addr,
  input  logic [WORD_BITS-1:0] wdata,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/aligned_free_page_range_finder.sv */
// Aligned free page range finder top level; depends on afprf_pkg, afprf_map_ram, afprf_divider.
// Reset starts a clearing pass that writes zero to every word of the page map; busy is high meanwhile.
// A mark transaction reads the map word, sets the page's bit to mapped_value and writes it back.
// A search runs two divisions, then per candidate scans map words from the top down and runs
// the step division after a hit; a rejected request goes straight to the result strobe.
// One transaction at a time; busy falls with the result strobe. The receiver cannot stall.
module aligned_free_page_range_finder
  import afprf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam logic [WIDE_BITS-1:0] SPACE = WIDE_BITS'(64'd1 << ADDR_BITS);
  localparam logic [WIDE_BITS-1:0] PMASK = WIDE_BITS'((64'd1 << PAGE_SHIFT) - 1);
  localparam logic [WIDE_BITS-1:0] PCNT  = WIDE_BITS'(64'd1 << PN_BITS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MRD, S_MWAIT, S_MWR, S_OFF, S_REM, S_CAND,
    S_SRD, S_SWAIT, S_SCHK, S_STEP, S_DONE
  } state_t;

  state_t state_r;
  in_item_t it_r;
  logic [WIDE_BITS-1:0] len_r, end_r, al_r, o_r, c_r, kfe_r, cend_r, lo_r, hi_r, num_r;
  logic [WIDX_BITS-1:0] w_r;
  logic [2:0]  st_r;
  logic [31:0] addr_r;
  logic        ov_r;

  logic                 we;
  logic [WIDX_BITS-1:0] ma;
  logic [WORD_BITS-1:0] wd, rd, bits;
  logic                 dgo, ddone;
  logic [WIDE_BITS-1:0] dnum, dquo, drem, beg_w, delta, from, step;
  logic [WIDE_BITS-1:0] last;
  logic [WORD_BITS-1:0] mhi, mlo;
  logic [5:0]           hb;

  afprf_map_ram u_ram (.clk, .we, .addr(ma), .wdata(wd), .rdata(rd));
  afprf_divider u_div (.clk, .rst_n, .go(dgo), .num(dnum), .den(al_r),
                       .done(ddone), .quo(dquo), .rem(drem));

  assign beg_w = {2'b0, it_r.search_begin};
  assign last  = hi_r - 1'b1;
  assign delta = (drem <= o_r) ? o_r - drem : al_r - (drem - o_r);
  assign from  = (c_r > kfe_r) ? c_r : kfe_r;
  assign step  = num_r - drem + al_r;
  assign mhi   = {WORD_BITS{1'b1}} >> (6'd63 - last[5:0]);
  assign mlo   = {WORD_BITS{1'b1}} << lo_r[5:0];

  always_comb begin
    bits = rd;
    if (w_r == last[PN_BITS-1:WSEL_BITS]) bits = bits & mhi;
    if (w_r == lo_r[PN_BITS-1:WSEL_BITS]) bits = bits & mlo;
    hb = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (bits[b]) hb = 6'(b);
    end
  end

  always_comb begin
    we = 1'b0;
    ma = w_r;
    wd = rd;
    if (state_r == S_CLEAR) begin
      we = 1'b1;
      wd = '0;
    end else if (state_r == S_MRD || state_r == S_MWAIT) begin
      ma = it_r.page_number[PN_BITS-1:WSEL_BITS];
    end else if (state_r == S_MWR) begin
      we = 1'b1;
      ma = it_r.page_number[PN_BITS-1:WSEL_BITS];
      wd[it_r.page_number[WSEL_BITS-1:0]] = it_r.mapped_value;
    end
  end

  always_comb begin
    dgo  = 1'b0;
    dnum = {1'b0, it_r.align_offset};
    if (state_r == S_OFF && !ov_r) dgo = 1'b1;
    if (state_r == S_REM && ov_r) begin
      dgo  = 1'b1;
      dnum = beg_w;
    end
    if (state_r == S_SCHK && bits != '0) begin
      dgo  = 1'b1;
      dnum = (((w_r * 34'd64) + 34'(hb)) << PAGE_SHIFT) - c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      w_r       <= '0;
      out_valid <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          w_r <= w_r + 1'b1;
          if (w_r == WIDX_BITS'(MAP_WORDS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            it_r    <= in_item;
            len_r   <= {1'b0, in_item.range_length};
            end_r   <= {1'b0, in_item.search_end};
            al_r    <= {1'b0, in_item.align_step};
            st_r    <= ST_OK;
            addr_r  <= '0;
            ov_r    <= 1'b0;
            state_r <= in_item.action ? S_OFF : S_MRD;
          end
        end
        S_MRD:   state_r <= S_MWAIT;
        S_MWAIT: state_r <= S_MWR;
        S_MWR:   state_r <= S_DONE;
        S_OFF: begin
          if (!ov_r) begin
            ov_r <= 1'b1;
            if (len_r == '0 || (len_r & PMASK) != '0 || end_r > SPACE ||
                beg_w >= end_r) begin
              st_r <= ST_BAD_RANGE; state_r <= S_DONE;
            end else if (len_r > SPACE) begin
              st_r <= ST_SIZE_OVER; state_r <= S_DONE;
            end else if (al_r == '0 || al_r > SPACE || (al_r & PMASK) != '0) begin
              st_r <= ST_BAD_ALIGN; state_r <= S_DONE;
            end
          end else if (ddone) begin
            o_r <= drem;
            if ((drem & PMASK) != '0) begin
              st_r <= ST_BAD_ALIGN; state_r <= S_DONE;
            end else state_r <= S_REM;
          end
        end
        S_REM: begin
          ov_r <= 1'b0;
          if (!ov_r && ddone) begin
            if (delta > SPACE - beg_w) begin
              st_r <= ST_NO_SPACE; state_r <= S_DONE;
            end else begin
              c_r <= beg_w + delta; kfe_r <= '0; state_r <= S_CAND;
            end
          end
        end
        S_CAND: begin
          if (c_r >= end_r || c_r > SPACE - len_r || len_r > end_r - c_r) begin
            st_r <= ST_NO_SPACE; state_r <= S_DONE;
          end else begin
            cend_r <= c_r + len_r;
            lo_r   <= from >> PAGE_SHIFT;
            hi_r   <= ((c_r + len_r) >> PAGE_SHIFT) > PCNT ? PCNT
                      : (c_r + len_r) >> PAGE_SHIFT;
            state_r <= S_SRD;
          end
        end
        S_SRD: begin
          if (lo_r >= hi_r) begin
            st_r <= ST_OK; addr_r <= c_r[31:0]; state_r <= S_DONE;
          end else begin
            w_r <= last[PN_BITS-1:WSEL_BITS]; state_r <= S_SWAIT;
          end
        end
        S_SWAIT: state_r <= S_SCHK;
        S_SCHK: begin
          if (bits != '0) begin
            kfe_r <= cend_r; num_r <= dnum; state_r <= S_STEP;
          end else if (w_r == lo_r[PN_BITS-1:WSEL_BITS]) begin
            st_r <= ST_OK; addr_r <= c_r[31:0]; state_r <= S_DONE;
          end else begin
            w_r <= w_r - 1'b1; state_r <= S_SWAIT;
          end
        end
        S_STEP: begin
          if (ddone) begin
            if (dquo >= SPACE || step > SPACE - c_r) begin
              st_r <= ST_NO_SPACE; state_r <= S_DONE;
            end else begin
              c_r <= c_r + step; state_r <= S_CAND;
            end
          end
        end
        S_DONE: begin
          out_valid              <= 1'b1;
          out_item.status        <= st_r;
          out_item.found_address <= (st_r == ST_OK) ? addr_r : '0;
          state_r                <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* tb/sv/aligned_free_page_range_finder_tb.sv */
// Self-checking testbench for the aligned free page range finder.
// Predicts every answer from its own copy of the page map and drives the start/busy port.
// Depends on afprf_pkg and aligned_free_page_range_finder.
import afprf_pkg::*;

class range_finder_model;
  localparam longint unsigned SPACE = 64'h1_0000_0000;
  localparam longint unsigned PAGE = 64'd4096;
  localparam longint unsigned PAGES = 64'd1 << 20;

  bit page_mapped[1 << 20];
  out_item_t expected_answers[$];
  int errors;

  function bit top_mapped(longint unsigned lo, longint unsigned hi,
                          output longint unsigned pg);
    longint unsigned p;
    if (hi > PAGES) hi = PAGES;
    for (p = hi; p > lo; p--) begin
      if (page_mapped[p - 1]) begin
        pg = p - 1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function logic [2:0] find_range(longint unsigned len, longint unsigned beg,
                                  longint unsigned lim, longint unsigned al,
                                  longint unsigned off, output logic [31:0] addr);
    longint unsigned o, rem, delta, c, free_end, from, pg, step;
    addr = '0;
    if (len == 0 || len % PAGE != 0 || lim > SPACE || beg >= lim) return ST_BAD_RANGE;
    if (len > SPACE) return ST_SIZE_OVER;
    if (al == 0 || al > SPACE || al % PAGE != 0) return ST_BAD_ALIGN;
    o = off % al;
    if (o % PAGE != 0) return ST_BAD_ALIGN;
    rem = beg % al;
    delta = (rem <= o) ? o - rem : al - (rem - o);
    if (delta > SPACE - beg) return ST_NO_SPACE;
    c = beg + delta;
    free_end = 0;
    while (c < lim) begin
      if (c > SPACE - len || len > lim - c) return ST_NO_SPACE;
      from = (c > free_end) ? c : free_end;
      if (!top_mapped(from >> 12, (c + len) >> 12, pg)) begin
        addr = c[31:0];
        return ST_OK;
      end
      free_end = c + len;
      step = (((pg << 12) - c) / al + 1) * al;
      if (step > SPACE - c) return ST_NO_SPACE;
      c += step;
    end
    return ST_NO_SPACE;
  endfunction

  function void note_request(in_item_t it);
    out_item_t ans;
    ans = '0;
    if (!it.action) begin
      page_mapped[it.page_number] = it.mapped_value;
    end else begin
      ans.status = find_range(it.range_length, it.search_begin, it.search_end,
                              it.align_step, it.align_offset, ans.found_address);
    end
    expected_answers.push_back(ans);
  endfunction

  function void check_answer(out_item_t got);
    out_item_t exp_ans;
    if (expected_answers.size() == 0) begin
      $display("%0t: unexpected result status=%0d addr=%h", $time, got.status,
               got.found_address);
      errors++;
      return;
    end
    exp_ans = expected_answers.pop_front();
    if (got.status !== exp_ans.status) begin
      $display("%0t: status expected %0d actual %0d", $time, exp_ans.status, got.status);
      errors++;
    end
    if (got.found_address !== exp_ans.found_address) begin
      $display("%0t: found_address expected %h actual %h", $time,
               exp_ans.found_address, got.found_address);
      errors++;
    end
  endfunction
endclass

module aligned_free_page_range_finder_tb;
  localparam logic [32:0] SPACE = 33'h1_0000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  int idle_pct;
  range_finder_model model = new();

  aligned_free_page_range_finder dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) model.check_answer(out_item);
  end

  function logic [32:0] rand33();
    return {1'($urandom_range(1, 0)), 32'($urandom())};
  endfunction

  task automatic issue(in_item_t it);
    if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    model.note_request(it);
  endtask

  task automatic mark(logic [19:0] pg, logic val);
    in_item_t it;
    it = '0;
    it.page_number = pg;
    it.mapped_value = val;
    it.range_length = rand33();
    it.search_end = rand33();
    issue(it);
  endtask

  task automatic seek(logic [32:0] len, logic [31:0] beg, logic [32:0] lim,
                      logic [32:0] al, logic [32:0] off);
    in_item_t it;
    it.action = 1'b1;
    it.page_number = 20'($urandom());
    it.mapped_value = 1'($urandom());
    it.range_length = len;
    it.search_begin = beg;
    it.search_end = lim;
    it.align_step = al;
    it.align_offset = off;
    issue(it);
  endtask

  task automatic random_item();
    in_item_t it;
    logic [32:0] len, lim, al, off;
    logic [31:0] beg;
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 10) begin
      it = {1'($urandom()), 20'($urandom()), 1'($urandom()), rand33(), 32'($urandom()),
            rand33(), rand33(), rand33()};
      if (it.action && it.range_length > 33'h4000_0000)
        it.range_length[32:28] = 5'd0;
      issue(it);
    end else if (pick < 55) begin
      if ($urandom_range(9, 0) == 0) mark(20'($urandom()), 1'($urandom()));
      else mark(20'($urandom_range(8191, 0)), $urandom_range(9, 0) < 6);
    end else begin
      len = 33'($urandom_range(16, 1)) << 12;
      if ($urandom_range(19, 0) == 0) len = len + 33'($urandom_range(4095, 1));
      al = 33'd4096 << $urandom_range(8, 0);
      off = ($urandom_range(7, 0) == 0) ? rand33() : 33'($urandom_range(255, 0)) << 12;
      beg = ($urandom_range(9, 0) == 0) ? 32'($urandom())
                                         : 32'($urandom_range(8191, 0)) * 4096
                                           + 32'($urandom_range(4095, 0));
      case ($urandom_range(5, 0))
        0: lim = SPACE;
        1: lim = rand33();
        default: lim = 33'(beg) + 33'($urandom_range(1 << 24, 1));
      endcase
      seek(len, beg, lim, al, off);
    end
  endtask

  initial begin
    #40000000;
    $display("aligned_free_page_range_finder_tb NOT OK");
    $finish;
  end

  initial begin
    idle_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    mark(20'd0, 1'b1);
    mark(20'hFFFFF, 1'b1);
    mark(20'd5, 1'b1);
    mark(20'd7, 1'b0);
    seek(33'd0, 32'd0, SPACE, 33'd4096, 33'd0);
    seek(33'd4095, 32'd0, SPACE, 33'd4096, 33'd0);
    seek(33'd4096, 32'd0, SPACE + 33'd1, 33'd4096, 33'd0);
    seek(33'd4096, 32'd8192, 33'd8192, 33'd4096, 33'd0);
    seek(SPACE + 33'd4096, 32'd0, SPACE, 33'd4096, 33'd0);
    seek(33'd4096, 32'd0, SPACE, 33'd0, 33'd0);
    seek(33'd4096, 32'd0, SPACE, SPACE + 33'd4096, 33'd0);
    seek(33'd4096, 32'd0, SPACE, 33'd2048, 33'd0);
    seek(33'd4096, 32'd0, SPACE, 33'd8192, 33'd2048);
    seek(33'd4096, 32'hFFFF_F000, SPACE, SPACE, 33'd0);
    seek(33'h1_FFFF_F000, 32'd0, SPACE, 33'd4096, 33'h1_FFFF_FFFF);
    seek(SPACE, 32'd0, SPACE, SPACE, 33'd0);
    seek(33'd16384, 32'd0, 33'h10_0000, 33'd4096, 33'd0);
    seek(33'd8192, 32'd1, SPACE, 33'd16384, 33'd20480);
    seek(33'd4096, 32'hFFFF_E000, SPACE, 33'd4096, 33'd0);
    mark(20'd0, 1'b0);
    mark(20'hFFFFF, 1'b0);
    seek(SPACE - 33'd4096, 32'd0, SPACE, SPACE, 33'd0);
    mark(20'd5, 1'b0);
    seek(SPACE, 32'd0, SPACE, SPACE, 33'd0);
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 63 : (phase == 3) ? 27 : 0;
      for (int n = 0; n < 350; n++) random_item();
    end
    start <= 1'b0;
    while (model.expected_answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (model.errors == 0) begin
      $display("aligned_free_page_range_finder_tb OK");
    end else begin
      $display("aligned_free_page_range_finder_tb NOT OK");
    end
    $finish;
  end
endmodule
